@@ rtl/adll_pkg.sv @@
// Shared definitions for the array doubly linked list unit.
// Holds command and status codes, field widths and the shared adder opcodes.
// Depends on nothing; adll_alu and the top level import it.
`default_nettype none

package adll_pkg;

  // Field widths of the input and result transactions.
  localparam int CMD_W  = 3;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Default node pool size.
  localparam int CAPACITY_DEF = 1024;

  // Sentinel entries of the pools.
  localparam int HEAD_NODE = 0;
  localparam int TAIL_NODE = 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_L = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_R = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_L  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_R  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WALK   = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_INC,
    ALU_GT
  } alu_op_t;

endpackage

`default_nettype wire

@@ rtl/adll_pool.sv @@
// Single write port, single registered read port memory for one node pool.
// Uses no package content; instantiated once per pool by the top level.
`default_nettype none

module adll_pool #(
  parameter int W     = 11,
  parameter int DEPTH = 1026,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/adll_alu.sv @@
// Shared adder of the sequencer: increments or compares two operands.
// Depends on adll_pkg for the operation codes.
`default_nettype none

module adll_alu import adll_pkg::*; #(
  parameter int W = 12
) (
  input  wire alu_op_t        op,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic      [W-1:0]   res,
  output logic                gt
);

  logic [W-1:0] b_op;
  logic [W:0]   full;

  // One adder computes a - b; an increment is a minus all ones.
  always_comb begin
    b_op = (op == ALU_INC) ? {W{1'b1}} : b;
    full = {1'b0, a} + {1'b0, ~b_op} + {{W{1'b0}}, 1'b1};
    res  = full[W-1:0];
    // Carry out means a >= b; a nonzero difference makes it strict.
    gt   = (op == ALU_GT) && full[W] && (full[W-1:0] != '0);
  end

endmodule

`default_nettype wire

@@ rtl/array_doubly_linked_list_unit.sv @@
// Each input transaction is run by the sequencer, and its result, with the status of a rejected
// position or a full pool, is loaded into the output register. A new transaction is taken
// the cycle after the result is loaded. The sequencer reads each pool memory at most once per
// cycle and uses a single shared adder. Synchronous reset clears the sentinel links, node
// count, cursor and output valid flag and returns the sequencer to idle.
// Depends on adll_pkg, adll_pool and adll_alu.
`default_nettype none

module array_doubly_linked_list_unit import adll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic [POS_W-1:0]        in_position,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      out_value_res,
  output logic                         out_at_end,
  output logic [STAT_W-1:0]            out_status
);

  localparam int POOL = CAPACITY + 2;
  localparam int IW   = $clog2(POOL);
  localparam int DW   = ((IW > POS_W) ? IW : POS_W) + 1;

  localparam logic [IW-1:0] HEAD = IW'(HEAD_NODE);
  localparam logic [IW-1:0] TAIL = IW'(TAIL_NODE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ENTRY,
    S_LIVE,
    S_PREV,
    S_DEL_LINK,
    S_CAP,
    S_FRESH,
    S_FRESH2,
    S_W1,
    S_W2,
    S_WALK_NX,
    S_WALK_CHK,
    S_WALK_VAL,
    S_DONE
  } state_t;

  state_t state_r;

  // Latched transaction and working registers.
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] k_r;
  logic [VAL_W-1:0] val_r;
  logic [IW-1:0]    ent_r;
  logic [IW-1:0]    at_r;
  logic [IW-1:0]    after_r;
  logic [IW-1:0]    fresh_r;
  logic [IW-1:0]    nx_r;

  // List state kept in flip-flops: sentinel links, count and cursor.
  logic [IW-1:0]    head_next_r;
  logic [IW-1:0]    tail_prev_r;
  logic [IW-1:0]    count_r;
  logic [IW-1:0]    cursor_r;

  // Result staging and output register.
  logic [VAL_W-1:0]  res_val_r;
  logic              res_end_r;
  logic [STAT_W-1:0] res_stat_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_end_r;
  logic [STAT_W-1:0] out_stat_r;

  // Shared adder.
  alu_op_t         alu_op;
  logic [DW-1:0]   alu_a;
  logic [DW-1:0]   alu_b;
  logic [DW-1:0]   alu_res;
  logic            alu_gt;

  // Pool memory ports.
  logic             nx_we, nx_re, pv_we, pv_re, lv_we, lv_re, vl_we, vl_re;
  logic [IW-1:0]    nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [IW-1:0]    lv_waddr, lv_raddr, vl_waddr, vl_raddr;
  logic [IW-1:0]    nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic             lv_wdata, lv_rdata;
  logic [VAL_W-1:0] vl_wdata, vl_rdata;

  adll_alu #(.W(DW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .gt  (alu_gt)
  );

  adll_pool #(.W(IW), .DEPTH(POOL)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
  );

  adll_pool #(.W(IW), .DEPTH(POOL)) u_prev (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(pv_re), .raddr(pv_raddr), .rdata(pv_rdata)
  );

  adll_pool #(.W(1), .DEPTH(POOL)) u_live (
    .clk, .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata)
  );

  adll_pool #(.W(VAL_W), .DEPTH(POOL)) u_value (
    .clk, .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
    .re(vl_re), .raddr(vl_raddr), .rdata(vl_rdata)
  );

  // Handshake outputs.
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value_res = out_val_r;
  assign out_at_end    = out_end_r;
  assign out_status    = out_stat_r;

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_INC;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_DISPATCH: begin
        alu_op = ALU_GT;
        alu_a  = DW'(k_r);
        alu_b  = DW'(count_r);
      end
      S_ENTRY: begin
        alu_a = DW'(k_r);
      end
      S_CAP: begin
        alu_op = ALU_GT;
        alu_a  = DW'(CAPACITY);
        alu_b  = DW'(count_r);
      end
      S_FRESH, S_FRESH2: begin
        alu_a = DW'(count_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Memory reads: each pool is read at most once per cycle.
  always_comb begin
    nx_re    = 1'b0;
    nx_raddr = cursor_r;
    pv_re    = 1'b0;
    pv_raddr = ent_r;
    lv_re    = (state_r == S_ENTRY);
    lv_raddr = alu_res[IW-1:0];
    vl_re    = (state_r == S_WALK_CHK) && (nx_r != TAIL);
    vl_raddr = nx_r;
    unique case (state_r)
      S_DISPATCH: begin
        nx_re = (cmd_r == CMD_WALK) && (cursor_r != HEAD);
      end
      S_LIVE: begin
        nx_re    = (cmd_r == CMD_DELETE);
        nx_raddr = ent_r;
        pv_re    = (cmd_r == CMD_DELETE) || (cmd_r == CMD_INS_L);
      end
      S_CAP: begin
        nx_re    = (at_r != HEAD);
        nx_raddr = at_r;
      end
      default: begin
        nx_re = 1'b0;
      end
    endcase
  end

  // Memory writes for unlinking and linking nodes.
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = fresh_r;
    nx_wdata = after_r;
    pv_we    = 1'b0;
    pv_waddr = fresh_r;
    pv_wdata = at_r;
    lv_we    = 1'b0;
    lv_waddr = fresh_r;
    lv_wdata = 1'b1;
    vl_we    = (state_r == S_W1);
    vl_waddr = fresh_r;
    vl_wdata = val_r;
    unique case (state_r)
      S_DEL_LINK: begin
        nx_we    = (pv_rdata != HEAD);
        nx_waddr = pv_rdata;
        nx_wdata = nx_rdata;
        pv_we    = (nx_rdata != TAIL);
        pv_waddr = nx_rdata;
        pv_wdata = pv_rdata;
        lv_we    = 1'b1;
        lv_waddr = ent_r;
        lv_wdata = 1'b0;
      end
      S_W1: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        lv_we = 1'b1;
      end
      S_W2: begin
        nx_we    = (at_r != HEAD);
        nx_waddr = at_r;
        nx_wdata = fresh_r;
        pv_we    = (after_r != TAIL);
        pv_waddr = after_r;
        pv_wdata = fresh_r;
      end
      default: begin
        nx_we = 1'b0;
      end
    endcase
  end

  // Sequencer, list registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_next_r <= TAIL;
      tail_prev_r <= HEAD;
      count_r     <= '0;
      cursor_r    <= HEAD;
    end else begin
      // The waiting result leaves when the receiver takes it, unless a new one replaces it.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_cmd;
            k_r        <= in_position;
            val_r      <= in_value;
            res_val_r  <= '0;
            res_end_r  <= 1'b0;
            res_stat_r <= ST_OK;
            state_r    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (cmd_r)
            CMD_PUSH_L: begin
              at_r    <= HEAD;
              state_r <= S_CAP;
            end
            CMD_PUSH_R: begin
              at_r    <= tail_prev_r;
              state_r <= S_CAP;
            end
            CMD_DELETE, CMD_INS_L, CMD_INS_R: begin
              if (alu_gt || (k_r == '0)) begin
                res_stat_r <= ST_BADPOS;
                state_r    <= S_DONE;
              end else begin
                state_r <= S_ENTRY;
              end
            end
            CMD_WALK: begin
              if (cursor_r == HEAD) begin
                nx_r    <= head_next_r;
                state_r <= S_WALK_CHK;
              end else begin
                state_r <= S_WALK_NX;
              end
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_ENTRY: begin
          ent_r   <= alu_res[IW-1:0];
          state_r <= S_LIVE;
        end
        S_LIVE: begin
          if (!lv_rdata) begin
            res_stat_r <= ST_BADPOS;
            state_r    <= S_DONE;
          end else if (cmd_r == CMD_DELETE) begin
            state_r <= S_DEL_LINK;
          end else if (cmd_r == CMD_INS_L) begin
            state_r <= S_PREV;
          end else begin
            at_r    <= ent_r;
            state_r <= S_CAP;
          end
        end
        S_PREV: begin
          at_r    <= pv_rdata;
          state_r <= S_CAP;
        end
        S_DEL_LINK: begin
          // Sentinel links live in flip-flops, the rest in the pools.
          if (pv_rdata == HEAD) begin
            head_next_r <= nx_rdata;
          end
          if (nx_rdata == TAIL) begin
            tail_prev_r <= pv_rdata;
          end
          cursor_r <= HEAD;
          state_r  <= S_DONE;
        end
        S_CAP: begin
          if (!alu_gt) begin
            res_stat_r <= ST_FULL;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_FRESH;
          end
        end
        S_FRESH: begin
          after_r <= (at_r == HEAD) ? head_next_r : nx_rdata;
          count_r <= alu_res[IW-1:0];
          state_r <= S_FRESH2;
        end
        S_FRESH2: begin
          fresh_r <= alu_res[IW-1:0];
          state_r <= S_W1;
        end
        S_W1: begin
          state_r <= S_W2;
        end
        S_W2: begin
          if (at_r == HEAD) begin
            head_next_r <= fresh_r;
          end
          if (after_r == TAIL) begin
            tail_prev_r <= fresh_r;
          end
          cursor_r <= HEAD;
          state_r  <= S_DONE;
        end
        S_WALK_NX: begin
          nx_r    <= nx_rdata;
          state_r <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (nx_r == TAIL) begin
            res_end_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            cursor_r <= nx_r;
            state_r  <= S_WALK_VAL;
          end
        end
        S_WALK_VAL: begin
          res_val_r <= vl_rdata;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          // Load the output register once it is free or being emptied.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_end_r   <= res_end_r;
            out_stat_r  <= res_stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
